@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the byte-level i2c master engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command codes as they arrive in the op field
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_t;

  // one bus tick as it travels through the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wbyte;
    logic       sda;
  } tick_t;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned BitsPerB = 8;

  localparam logic [7:0] PollLimitReset = 8'hff;

endpackage

@@ rtl/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// i2cm_front
// Takes tick words from the input stream, decodes the op field and pushes
// the classified tick into the queue.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] write_byte, [8] sda_sample, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  input  logic        q_full,
  output logic        q_push,
  output tick_t       q_wdata
);

  cmd_t cmd;

  // undefined op codes fall back to a plain tick
  always_comb begin
    unique case (s_axis_tuser)
      CMD_START:     cmd = CMD_START;
      CMD_STOP:      cmd = CMD_STOP;
      CMD_WRITE:     cmd = CMD_WRITE;
      CMD_READ_ACK:  cmd = CMD_READ_ACK;
      CMD_READ_NACK: cmd = CMD_READ_NACK;
      default:       cmd = CMD_TICK;
    endcase
  end

  assign s_axis_tready   = ~q_full & ~rst;
  assign q_push          = s_axis_tvalid & s_axis_tready;
  assign q_wdata.cmd     = cmd;
  assign q_wdata.wbyte   = s_axis_tdata[7:0];
  assign q_wdata.sda     = s_axis_tdata[8];

endmodule

@@ rtl/i2cm_queue.sv @@
// ----------------------------------------------------------------------------
// i2cm_queue
// Small flop-based fifo of classified ticks between front and back.
// ----------------------------------------------------------------------------
module i2cm_queue import i2cm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  tick_t wdata,
  output logic  full,
  input  logic  pop,
  output tick_t rdata,
  output logic  empty
);

  tick_t            mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic [QCntW-1:0] count_next;

  assign full  = (count == QCntW'(QDepth));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_comb begin
    count_next = count;
    priority if (push && !pop) begin
      count_next = count + QCntW'(1);
    end else if (pop && !push) begin
      count_next = count - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ rtl/i2cm_back.sv @@
// ----------------------------------------------------------------------------
// i2cm_back
// Bus phase sequencer: steps one tick per queue word, drives the line
// levels and holds the result word in an output register.
// ----------------------------------------------------------------------------
module i2cm_back import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  tick_t       q_rdata,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_STOP  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t     state, state_next, st_cur;
  logic [2:0] phase, phase_next, ph_cur;
  logic [3:0] bit_idx, bit_idx_next, bit_cur, bit_inc;
  logic [7:0] shift, shift_next, sh_cur, sh_rd;
  logic [7:0] poll_left, poll_left_next;
  logic [7:0] poll_limit;
  logic       nack, nack_next;
  logic       scl, scl_next;
  logic       sdo, sdo_next;
  logic       drv, drv_next;
  logic [7:0] last_rd, last_rd_next;
  logic       done;
  logic       status;
  logic       sda_line;

  assign q_pop = ~q_empty & (~m_axis_tvalid | m_axis_tready);

  // command latch at idle
  always_comb begin
    st_cur    = state;
    ph_cur    = phase;
    bit_cur   = bit_idx;
    sh_cur    = shift;
    nack_next = nack;
    if (state == ST_IDLE) begin
      unique case (q_rdata.cmd)
        CMD_START:     st_cur = ST_START;
        CMD_STOP:      st_cur = ST_STOP;
        CMD_WRITE:     st_cur = ST_WRITE;
        CMD_READ_ACK: begin
          st_cur    = ST_READ;
          nack_next = 1'b0;
        end
        CMD_READ_NACK: begin
          st_cur    = ST_READ;
          nack_next = 1'b1;
        end
        default: st_cur = ST_IDLE;
      endcase
      if (q_rdata.cmd != CMD_TICK) begin
        ph_cur  = '0;
        bit_cur = '0;
        sh_cur  = (q_rdata.cmd == CMD_WRITE) ? q_rdata.wbyte : 8'h00;
      end
    end
  end

  assign bit_inc = bit_cur + 4'd1;
  assign sh_rd   = {sh_cur[6:0], q_rdata.sda};

  always_comb begin
    state_next     = st_cur;
    phase_next     = ph_cur;
    bit_idx_next   = bit_cur;
    shift_next     = sh_cur;
    poll_left_next = poll_left;
    scl_next       = scl;
    sdo_next       = sdo;
    drv_next       = drv;
    last_rd_next   = last_rd;
    done           = 1'b0;
    status         = 1'b0;
    unique case (st_cur)
      ST_IDLE: begin
      end
      ST_START: begin
        priority case (ph_cur)
          3'd0: begin
            drv_next   = 1'b1;
            scl_next   = 1'b1;
            phase_next = 3'd1;
          end
          3'd1: begin
            sdo_next   = 1'b1;
            phase_next = 3'd2;
          end
          3'd2: begin
            sdo_next   = 1'b0;
            phase_next = 3'd3;
          end
          default: begin
            if (ph_cur == 3'd3) begin
              scl_next = 1'b0;
            end
            done = 1'b1;
          end
        endcase
      end
      ST_STOP: begin
        priority case (ph_cur)
          3'd0: begin
            scl_next   = 1'b0;
            drv_next   = 1'b1;
            sdo_next   = 1'b0;
            phase_next = 3'd1;
          end
          3'd1: begin
            scl_next   = 1'b1;
            phase_next = 3'd2;
          end
          default: begin
            if (ph_cur == 3'd2) begin
              sdo_next = 1'b1;
            end
            done = 1'b1;
          end
        endcase
      end
      ST_WRITE: begin
        priority case (ph_cur)
          3'd0: begin
            // no falling clock edge ahead of the first bit
            if (bit_cur != 4'd0) begin
              scl_next = 1'b0;
            end
            drv_next   = 1'b1;
            sdo_next   = sh_cur[7];
            phase_next = 3'd1;
          end
          3'd1: begin
            scl_next     = 1'b1;
            shift_next   = {sh_cur[6:0], 1'b0};
            bit_idx_next = bit_inc;
            phase_next   = (bit_inc >= 4'(BitsPerB)) ? 3'd2 : 3'd0;
          end
          3'd2: begin
            scl_next   = 1'b0;
            drv_next   = 1'b0;
            phase_next = 3'd3;
          end
          3'd3: begin
            scl_next       = 1'b1;
            poll_left_next = poll_limit;
            phase_next     = 3'd4;
          end
          3'd4: begin
            priority if (!q_rdata.sda) begin
              scl_next = 1'b0;
              drv_next = 1'b1;
              sdo_next = 1'b1;
              done     = 1'b1;
            end else if (poll_left <= 8'd1) begin
              // ack timeout: no device
              poll_left_next = '0;
              scl_next       = 1'b0;
              drv_next       = 1'b1;
              sdo_next       = 1'b1;
              status         = 1'b1;
              done           = 1'b1;
            end else begin
              poll_left_next = poll_left - 8'd1;
            end
          end
          default: done = 1'b1;
        endcase
      end
      ST_READ: begin
        priority case (ph_cur)
          3'd0: begin
            drv_next   = 1'b0;
            phase_next = 3'd1;
          end
          3'd1: begin
            scl_next   = 1'b0;
            phase_next = 3'd2;
          end
          3'd2: begin
            scl_next     = 1'b1;
            shift_next   = sh_rd;
            bit_idx_next = bit_inc;
            if (bit_inc >= 4'(BitsPerB)) begin
              last_rd_next = sh_rd;
              phase_next   = 3'd3;
            end else begin
              phase_next = 3'd1;
            end
          end
          3'd3: begin
            scl_next   = 1'b0;
            drv_next   = 1'b1;
            phase_next = 3'd4;
          end
          3'd4: begin
            sdo_next   = nack_next;
            phase_next = 3'd5;
          end
          3'd5: begin
            scl_next   = 1'b1;
            phase_next = 3'd6;
          end
          default: begin
            if (ph_cur == 3'd6) begin
              scl_next = 1'b0;
            end
            done = 1'b1;
          end
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
    if (done) begin
      state_next   = ST_IDLE;
      phase_next   = '0;
      bit_idx_next = '0;
    end
  end

  // released line reads as the pulled-up level
  assign sda_line = drv_next ? sdo_next : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= PollLimitReset;
    end else if (cfg_wr_en) begin
      poll_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= '0;
      bit_idx       <= '0;
      shift         <= '0;
      poll_left     <= '0;
      nack          <= 1'b0;
      scl           <= 1'b1;
      sdo           <= 1'b1;
      drv           <= 1'b1;
      last_rd       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        state     <= state_next;
        phase     <= phase_next;
        bit_idx   <= bit_idx_next;
        shift     <= shift_next;
        poll_left <= poll_left_next;
        nack      <= nack_next;
        scl       <= scl_next;
        sdo       <= sdo_next;
        drv       <= drv_next;
        last_rd   <= last_rd_next;
      end
      if (q_pop) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_axis_tdata <= {2'b00, status, last_rd_next, done,
                       (state_next != ST_IDLE), drv_next, sda_line, scl_next};
    end
  end

endmodule

@@ rtl/i2c_master_byte_engine_top.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// Byte-level i2c master, one bus timing tick per stream word.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one word per bus tick: the sampled sda level, a byte to
//   write and, in tuser, the op (start, stop, write, read with ack/nack).
//   an op is only taken while the engine is idle; otherwise it is ignored.
//   m_axis returns exactly one word per input word with the scl/sda levels,
//   sda drive enable, busy, done, the last read byte and the ack status.
//   cfg_wr_en/cfg_wr_data set the ack poll limit; write it while idle.
// timing:
//   a word enters a 4-deep queue on acceptance and its result is registered
//   in the output register once the word is popped from the queue.
//   one word per cycle sustained while m_axis is ready, one phase step per word.
// reset:
//   rst clears the queue and output valid; lines come up high and driven,
//   poll limit 255, read byte 0.
// stall:
//   while m_axis_tready is low the result word holds, the queue fills and
//   then s_axis_tready drops until space frees up.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] write_byte, [8] sda_sample
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] scl_level, [1] sda_level, [2] sda_drive,
                                      // [3] busy_res, [4] done_res, [12:5] read_byte,
                                      // [13] status
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  tick_t q_wdata;
  tick_t q_rdata;

  i2cm_front u_front (
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  i2cm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  i2cm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ rtl/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the i2c master engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a completing word never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]))
    else $error("done and busy set in the same word");

  // no-device status only on a done word
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[13]) |-> m_axis_tdata[4])
    else $error("status set without done");

  // released sda shows the pulled-up level
  a_released_high: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> m_axis_tdata[1])
    else $error("sda level low while released");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed under stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
